>>> sv/rss_pkg.sv
// rss_pkg: shared types, codes and sizes for the randomized set unit
// no dependencies
package rss_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_RANDOM = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [14:0]        random_value;
  } in_beat_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic signed [31:0] member;
    logic [6:0]         size_after;
  } out_beat_t;

  typedef struct packed {
    logic            start;
    logic [14:0]     dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CntW-1:0] rem;
  } div_rsp_t;
endpackage

>>> sv/rss_mod_div.sv
// rss_mod_div: restoring remainder unit, one dividend bit per cycle
// depends on rss_pkg
module rss_mod_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rss_pkg::div_req_t req,
  output rss_pkg::div_rsp_t rsp
);
  import rss_pkg::*;

  logic [14:0]     num_r, num_nxt;
  logic [CntW-1:0] den_r, den_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[14]};
    if (req.start) begin
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CntW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = CntW'(trial);
      end
      num_nxt = {num_r[13:0], 1'b0};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd14) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
endmodule

>>> sv/randomized_set_swap_remove_unit.sv
// randomized_set_swap_remove_unit: top level, store, parallel match, sequencer
// depends on rss_pkg and rss_mod_div
//
// in_ channel: one beat per operation (insert, remove, get-random).
// out_ channel: exactly one result beat per operation, in order.
// One operation is in flight at a time; in_stall is high from acceptance
// until the result beat has been taken.
// Insert and miss cases go from execute straight to the result; remove
// adds a swap step (read last entry, write it into the freed slot), and
// get-random waits on the serial remainder unit, then does a store read.
// The next beat is taken the cycle after the result beat leaves.
// The element store is a 64 x 32 memory with a registered read; the match
// over live entries compares all slots of a shadow copy of the values
// combinationally.
// Reset empties the set (count zero); store contents need no clearing.
// While out_stall is high the result beat holds and no new beat is taken.
module randomized_set_swap_remove_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rss_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rss_pkg::out_beat_t out_data
);
  import rss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SWAP = 6'b000100,
    S_DIV  = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  in_beat_t        op_r, op_nxt;
  out_beat_t       res_r, res_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [IdxW-1:0] slot_r, slot_nxt;
  logic [31:0]     store [Capacity];
  logic [31:0]     shadow_r [Capacity];
  logic [31:0]     rdata_r;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [31:0]     wdata;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  div_req_t        dreq;
  div_rsp_t        drsp;

  rss_mod_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (CntW'(i) < count_r && shadow_r[i] == op_r.value) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    slot_nxt  = slot_r;
    raddr     = IdxW'(count_r - CntW'(1));
    we        = 1'b0;
    waddr     = IdxW'(count_r);
    wdata     = op_r.value;
    dreq      = '{start: 1'b0, dividend: op_r.random_value, divisor: count_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt = '{success: 1'b0, status: ST_MISS, member: '0,
                    size_after: 7'(count_r)};
        state_nxt = S_OUT;
        priority if (op_r.operation == OP_INSERT) begin
          if (hit) begin
            res_nxt.status = ST_MISS;
          end else if (count_r >= CntW'(Capacity)) begin
            res_nxt.status = ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CntW'(1);
            res_nxt   = '{success: 1'b1, status: ST_DONE, member: '0,
                          size_after: 7'(count_nxt)};
          end
        end else if (op_r.operation == OP_REMOVE) begin
          if (hit) begin
            slot_nxt  = hit_idx;
            state_nxt = S_SWAP;
          end
        end else if (op_r.operation == OP_RANDOM) begin
          if (count_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            dreq.start = 1'b1;
            state_nxt  = S_DIV;
          end
        end else begin
          res_nxt.status = ST_MISS;
        end
      end
      S_SWAP: begin
        we        = 1'b1;
        waddr     = slot_r;
        wdata     = rdata_r;
        count_nxt = count_r - CntW'(1);
        res_nxt   = '{success: 1'b1, status: ST_DONE, member: '0,
                      size_after: 7'(count_nxt)};
        state_nxt = S_OUT;
      end
      S_DIV: begin
        raddr = IdxW'(drsp.rem);
        if (drsp.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        res_nxt   = '{success: 1'b1, status: ST_DONE, member: rdata_r,
                      size_after: 7'(count_r)};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr]    <= wdata;
      shadow_r[waddr] <= wdata;
    end
    rdata_r <= store[raddr];
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    res_r  <= res_nxt;
    slot_r <= slot_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Capacity)) else $error("count above capacity");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == S_EXEC
      || $past(state_r) == S_SWAP) else $error("count changed outside update");
  a_out_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.size_after == 7'(count_r)) else $error("size mismatch");
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.success == (out_data.status == ST_DONE))
    else $error("success and status disagree");
endmodule

>>> tb/tb_randomized_set_swap_remove_unit.sv
// tb_randomized_set_swap_remove_unit: self-checking bench for the randomized set unit
// drives operation beats, predicts each result with a local set model, compares in order
// depends on rss_pkg and randomized_set_swap_remove_unit
`timescale 1ns / 1ps

module tb_randomized_set_swap_remove_unit;
  import rss_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  randomized_set_swap_remove_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    in_beat_t  beat;
    logic      fixed;
    out_beat_t want;
  } row_t;

  logic [31:0] set_vals [Capacity];
  int          set_count;
  out_beat_t   pending_results [$];
  int          errors;
  logic        sink_hold;
  logic        no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  function automatic out_beat_t predict_set_op(in_beat_t b);
    out_beat_t r;
    int        slot;
    r = '0;
    r.status = ST_MISS;
    slot = -1;
    for (int i = 0; i < set_count; i++)
      if (slot < 0 && set_vals[i] == b.value) slot = i;
    case (b.operation)
      OP_INSERT: begin
        if (slot >= 0) r.status = ST_MISS;
        else if (set_count >= Capacity) r.status = ST_FULL;
        else begin
          set_vals[set_count] = b.value;
          set_count++;
          r.success = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          set_vals[slot] = set_vals[set_count - 1];
          set_count--;
          r.success = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_RANDOM: begin
        if (set_count == 0) r.status = ST_EMPTY;
        else begin
          r.member = set_vals[int'(b.random_value) % set_count];
          r.success = 1'b1;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.size_after = set_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) report_mismatch("unexpected beat", 64'(out_data), '0);
      else begin
        w = pending_results.pop_front();
        if (out_data.success !== w.success)
          report_mismatch("success", 64'(out_data.success), 64'(w.success));
        if (out_data.status !== w.status)
          report_mismatch("status", 64'(out_data.status), 64'(w.status));
        if (out_data.member !== w.member)
          report_mismatch("member", 64'(out_data.member), 64'(w.member));
        if (out_data.size_after !== w.size_after)
          report_mismatch("size_after", 64'(out_data.size_after), 64'(w.size_after));
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(in_beat_t b, logic fixed, out_beat_t want);
    out_beat_t p;
    int        gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk iff !in_stall);
    p = predict_set_op(b);
    pending_results = {pending_results, (fixed ? want : p)};
    if (fixed && p !== want) report_mismatch("table row", 64'(p), 64'(want));
  endtask

  function automatic in_beat_t mk(logic [1:0] op, logic [31:0] v, logic [14:0] r);
    in_beat_t b;
    b.operation = op;
    b.value = v;
    b.random_value = r;
    return b;
  endfunction

  function automatic out_beat_t res(logic s, logic [1:0] st, logic [31:0] m, int sz);
    out_beat_t o;
    o.success = s;
    o.status = st;
    o.member = m;
    o.size_after = sz[6:0];
    return o;
  endfunction

  function automatic logic [31:0] pick_value(bit known);
    if (known && set_count > 0) return set_vals[$urandom_range(0, set_count - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    row_t      tbl [$];
    row_t      rw;
    in_beat_t  b;
    logic [1:0] op;
    int        phase_len;
    errors = 0;
    set_count = 0;
    sink_hold = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: fixed rows read off the spec, others predicted
    rw.fixed = 1; rw.beat = mk(OP_RANDOM, 0, 15'h7FFF); rw.want = res(0, ST_EMPTY, 0, 0); tbl = {tbl, rw};
    rw.beat = mk(OP_REMOVE, 5, 0);            rw.want = res(0, ST_MISS, 0, 0);  tbl = {tbl, rw};
    rw.beat = mk(OP_NONE, 32'hFFFF_FFFF, 15'h7FFF); rw.want = res(0, ST_MISS, 0, 0); tbl = {tbl, rw};
    rw.beat = mk(OP_INSERT, 32'h8000_0000, 0); rw.want = res(1, ST_DONE, 0, 1); tbl = {tbl, rw};
    rw.beat = mk(OP_INSERT, 32'h8000_0000, 0); rw.want = res(0, ST_MISS, 0, 1); tbl = {tbl, rw};
    rw.beat = mk(OP_RANDOM, 32'hFFFF_FFFF, 15'h7FFF);
    rw.want = res(1, ST_DONE, 32'h8000_0000, 1); tbl = {tbl, rw};
    rw.beat = mk(OP_INSERT, 32'h7FFF_FFFF, 0); rw.want = res(1, ST_DONE, 0, 2); tbl = {tbl, rw};
    rw.beat = mk(OP_INSERT, 0, 0);            rw.want = res(1, ST_DONE, 0, 3); tbl = {tbl, rw};
    rw.fixed = 0;
    rw.beat = mk(OP_RANDOM, 0, 15'h7FFF); tbl = {tbl, rw};
    rw.beat = mk(OP_RANDOM, 0, 0);        tbl = {tbl, rw};
    rw.beat = mk(OP_REMOVE, 32'h8000_0000, 0); tbl = {tbl, rw};
    rw.beat = mk(OP_REMOVE, 0, 0);        tbl = {tbl, rw};
    rw.beat = mk(OP_RANDOM, 0, 15'h1234); tbl = {tbl, rw};
    rw.beat = mk(OP_REMOVE, 32'h7FFF_FFFF, 0); tbl = {tbl, rw};
    rw.beat = mk(OP_RANDOM, 0, 15'h5555); tbl = {tbl, rw};
    foreach (tbl[i]) send_beat(tbl[i].beat, tbl[i].fixed, tbl[i].want);

    // fill to capacity, then full, present-while-full, random and remove cases
    wait_drained;
    for (int i = 0; i < Capacity; i++) send_beat(mk(OP_INSERT, 32'h1000 + i, 0), 0, '0);
    send_beat(mk(OP_INSERT, 32'hDEAD_BEEF, 0), 1, res(0, ST_FULL, 0, Capacity));
    send_beat(mk(OP_INSERT, 32'h1000, 0), 1, res(0, ST_MISS, 0, Capacity));
    send_beat(mk(OP_RANDOM, 0, 15'h7FFF), 0, '0);
    send_beat(mk(OP_REMOVE, 32'h1000 + Capacity - 1, 0), 0, '0);

    // long receiver hold while the sender keeps offering
    sink_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_beat(mk(OP_RANDOM, 0, 15'($urandom)), 0, '0);
    join

    // sender pause until all results are back
    wait_drained;

    // random phases with drifting insert bias
    for (int ph = 0; ph < 8; ph++) begin
      phase_len = 100;
      if (ph == 7) no_idle = 1'b1;
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: op = OP_INSERT;
          3:       op = (ph % 2) ? OP_REMOVE : OP_INSERT;
          4, 5:    op = OP_REMOVE;
          6, 7, 8: op = OP_RANDOM;
          default: op = OP_NONE;
        endcase
        b = mk(op, pick_value($urandom_range(0, 1) == 1), 15'($urandom));
        send_beat(b, 0, '0);
      end
    end

    wait_drained;
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/rss_pkg.sv
sv/rss_mod_div.sv
sv/randomized_set_swap_remove_unit.sv
tb/tb_randomized_set_swap_remove_unit.sv
